@@ rtl/core/rotation_matrix_to_quaternion_top_macros.svh @@
// assertion macros for the rotation matrix to quaternion block
// used by the port checker; needs nothing else
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

// checked only out of reset
`define RMQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define RMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rmq_pkg.sv @@
// shared types for the rotation matrix to quaternion pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    // which component takes the square root term
    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } branch_t;

endpackage

`default_nettype wire

@@ rtl/core/rotation_matrix_to_quaternion_top.sv @@
// rotation matrix to quaternion, four-branch trace method, fixed point
// pipeline: front register, root stages, divide stages, output register,
//   QW = ceil((DATA_WIDTH+2+FRAC_BITS)/2) root stages, DVW = DATA_WIDTH+1+FRAC_BITS divide stages;
//   one matrix per cycle while the output is not stalled, set by the bit-per-stage root and dividers
// the whole pipeline holds while the output register is full and not taken
// synchronous active-low reset clears all valid bits; no other state
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS = 14
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up, zero padded
    input  wire [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // qw, qx, qy, qz from the lowest bit up, zero padded
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic [0:0]             m_tuser
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int RW   = W + 2 + F;
    localparam int QW   = (RW + 1) / 2;
    localparam int DSW  = QW + 1;
    localparam int NUMW = W + 1;
    localparam int DVW  = NUMW + F;
    localparam int OW   = QW - 1;
    localparam int OTW  = ((4*W+7)/8)*8;
    localparam int SQ_SIDE = 1 + 2 + 3*NUMW;

    logic ce;
    assign ce = !m_tvalid || m_tready;
    assign s_tready = ce;

    // front stage
    logic              f_v, f_degen;
    branch_t           f_branch;
    logic [RW-1:0]     f_rad;
    logic signed [W:0] f_n0, f_n1, f_n2;

    rmq_front #(.W(W), .F(F), .RW(RW)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .v_in       (s_tvalid),
        .m00        (s_tdata[0*W +: W]),
        .m01        (s_tdata[1*W +: W]),
        .m02        (s_tdata[2*W +: W]),
        .m10        (s_tdata[3*W +: W]),
        .m11        (s_tdata[4*W +: W]),
        .m12        (s_tdata[5*W +: W]),
        .m20        (s_tdata[6*W +: W]),
        .m21        (s_tdata[7*W +: W]),
        .m22        (s_tdata[8*W +: W]),
        .v_out      (f_v),
        .branch_out (f_branch),
        .degen_out  (f_degen),
        .rad_out    (f_rad),
        .n0_out     (f_n0),
        .n1_out     (f_n1),
        .n2_out     (f_n2)
    );

    // square root
    logic               r_v;
    logic [QW-1:0]      r_root;
    logic [SQ_SIDE-1:0] r_side;
    logic               r_degen;
    logic [1:0]         r_branch;
    logic signed [W:0]  r_n0, r_n1, r_n2;
    logic [DSW-1:0]     r_s;

    rmq_sqrt #(.IN_W(RW), .SIDE_W(SQ_SIDE), .QW(QW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .v_in     (f_v),
        .n_in     (f_rad),
        .side_in  ({f_degen, f_branch, f_n0, f_n1, f_n2}),
        .v_out    (r_v),
        .root_out (r_root),
        .side_out (r_side)
    );

    assign {r_degen, r_branch, r_n0, r_n1, r_n2} = r_side;
    assign r_s = {r_root, 1'b0};

    // three dividers; the side data is split among them
    logic           d_v;
    logic [DVW-1:0] d_quo0, d_quo1, d_quo2;
    logic           d_neg0, d_neg1, d_neg2;
    logic [1:0]     d_branch;
    logic [OW-1:0]  d_own;
    logic           d_degen;

    rmq_div #(.NUM_W(NUMW), .DSW(DSW), .FRAC(F), .SIDE_W(2), .DVW(DVW)) u_div0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .v_in     (r_v),
        .num_in   (r_n0),
        .den_in   (r_s),
        .side_in  (r_branch),
        .v_out    (d_v),
        .quo_out  (d_quo0),
        .neg_out  (d_neg0),
        .side_out (d_branch)
    );

    rmq_div #(.NUM_W(NUMW), .DSW(DSW), .FRAC(F), .SIDE_W(OW), .DVW(DVW)) u_div1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .v_in     (r_v),
        .num_in   (r_n1),
        .den_in   (r_s),
        .side_in  (r_root[QW-1:1]),
        .v_out    (),
        .quo_out  (d_quo1),
        .neg_out  (d_neg1),
        .side_out (d_own)
    );

    rmq_div #(.NUM_W(NUMW), .DSW(DSW), .FRAC(F), .SIDE_W(1), .DVW(DVW)) u_div2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .v_in     (r_v),
        .num_in   (r_n2),
        .den_in   (r_s),
        .side_in  (r_degen),
        .v_out    (),
        .quo_out  (d_quo2),
        .neg_out  (d_neg2),
        .side_out (d_degen)
    );

    // output stage
    logic [W-1:0] o_qw, o_qx, o_qy, o_qz;
    logic         o_degen;

    rmq_out #(.W(W), .DVW(DVW), .OW(OW)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .v_in      (d_v),
        .branch_in (branch_t'(d_branch)),
        .degen_in  (d_degen),
        .own_in    (d_own),
        .quo0_in   (d_quo0),
        .neg0_in   (d_neg0),
        .quo1_in   (d_quo1),
        .neg1_in   (d_neg1),
        .quo2_in   (d_quo2),
        .neg2_in   (d_neg2),
        .v_out     (m_tvalid),
        .qw_out    (o_qw),
        .qx_out    (o_qx),
        .qy_out    (o_qy),
        .qz_out    (o_qz),
        .degen_out (o_degen)
    );

    assign m_tdata = OTW'({o_qz, o_qy, o_qx, o_qw});
    assign m_tuser = o_degen;

endmodule

`default_nettype wire

@@ rtl/core/rmq_front.sv @@
// branch selection, radicand and numerator formation (one register stage)
// depends on rmq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmq_front
    import rmq_pkg::*;
#(
    parameter int W = 16,
    parameter int F = 14,
    parameter int RW = W + 2 + F
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  ce,
    input  wire                  v_in,
    input  wire signed [W-1:0]   m00,
    input  wire signed [W-1:0]   m01,
    input  wire signed [W-1:0]   m02,
    input  wire signed [W-1:0]   m10,
    input  wire signed [W-1:0]   m11,
    input  wire signed [W-1:0]   m12,
    input  wire signed [W-1:0]   m20,
    input  wire signed [W-1:0]   m21,
    input  wire signed [W-1:0]   m22,
    output logic                 v_out,
    output branch_t              branch_out,
    output logic                 degen_out,
    output logic [RW-1:0]        rad_out,
    output logic signed [W:0]    n0_out,
    output logic signed [W:0]    n1_out,
    output logic signed [W:0]    n2_out
);

    localparam int EW = W + 3;
    localparam logic signed [EW-1:0] ONE = EW'(1) << F;

    logic signed [EW-1:0] e00, e11, e22, trace, rad;
    logic signed [W:0] n0, n1, n2;
    branch_t branch;
    logic degen;

    logic v_reg;
    branch_t branch_reg;
    logic degen_reg;
    logic [RW-1:0] rad_reg;
    logic signed [W:0] n0_reg, n1_reg, n2_reg;

    always_comb begin
        e00 = EW'(m00);
        e11 = EW'(m11);
        e22 = EW'(m22);
        trace = e00 + e11 + e22;
        if (trace > 0) begin
            branch = BR_W;
        end else if (m00 > m11 && m00 > m22) begin
            branch = BR_X;
        end else if (m11 > m22) begin
            branch = BR_Y;
        end else begin
            branch = BR_Z;
        end
        case (branch)
            BR_W: begin
                rad = ONE + trace;
                n0 = (W+1)'(m21) - (W+1)'(m12);
                n1 = (W+1)'(m02) - (W+1)'(m20);
                n2 = (W+1)'(m10) - (W+1)'(m01);
            end
            BR_X: begin
                rad = ONE + e00 - e11 - e22;
                n0 = (W+1)'(m21) - (W+1)'(m12);
                n1 = (W+1)'(m01) + (W+1)'(m10);
                n2 = (W+1)'(m02) + (W+1)'(m20);
            end
            BR_Y: begin
                rad = ONE + e11 - e00 - e22;
                n0 = (W+1)'(m02) - (W+1)'(m20);
                n1 = (W+1)'(m01) + (W+1)'(m10);
                n2 = (W+1)'(m12) + (W+1)'(m21);
            end
            default: begin
                rad = ONE + e22 - e00 - e11;
                n0 = (W+1)'(m10) - (W+1)'(m01);
                n1 = (W+1)'(m02) + (W+1)'(m20);
                n2 = (W+1)'(m12) + (W+1)'(m21);
            end
        endcase
        degen = rad[EW-1] || (rad == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (ce) begin
            v_reg <= v_in;
        end
        if (ce) begin
            branch_reg <= branch;
            degen_reg  <= degen;
            // radicand scaled by 2^F for the fixed-point root
            rad_reg    <= degen ? '0 : {rad[W+1:0], {F{1'b0}}};
            n0_reg     <= n0;
            n1_reg     <= n1;
            n2_reg     <= n2;
        end
    end

    assign v_out      = v_reg;
    assign branch_out = branch_reg;
    assign degen_out  = degen_reg;
    assign rad_out    = rad_reg;
    assign n0_out     = n0_reg;
    assign n1_out     = n1_reg;
    assign n2_out     = n2_reg;

endmodule

`default_nettype wire

@@ rtl/core/rmq_sqrt.sv @@
// pipelined integer square root, one result bit per stage
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module rmq_sqrt #(
    parameter int IN_W = 32,
    parameter int SIDE_W = 8,
    parameter int QW = (IN_W + 1) / 2
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               ce,
    input  wire               v_in,
    input  wire [IN_W-1:0]    n_in,
    input  wire [SIDE_W-1:0]  side_in,
    output logic              v_out,
    output logic [QW-1:0]     root_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int NW = 2 * QW;

    logic              v_reg    [0:QW-1];
    logic [QW+1:0]     rem_reg  [0:QW-1];
    logic [QW-1:0]     root_reg [0:QW-1];
    logic [NW-1:0]     n_reg    [0:QW-1];
    logic [SIDE_W-1:0] side_reg [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic              v_i;
        logic [QW+1:0]     rem_i, rem_sh, trial, rem_next;
        logic [QW-1:0]     root_i, root_next;
        logic [NW-1:0]     n_i;
        logic [SIDE_W-1:0] side_i;

        if (k == 0) begin : g_first
            assign v_i    = v_in;
            assign rem_i  = '0;
            assign root_i = '0;
            assign n_i    = NW'(n_in);
            assign side_i = side_in;
        end else begin : g_next
            assign v_i    = v_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign n_i    = n_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        always_comb begin
            // bring down the next two radicand bits, try root*4+1
            rem_sh = {rem_i[QW-1:0], n_i[NW-1:NW-2]};
            trial  = {root_i, 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_i[QW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_i[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= v_i;
            end
            if (ce) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                n_reg[k]    <= n_i << 2;
                side_reg[k] <= side_i;
            end
        end
    end

    assign v_out    = v_reg[QW-1];
    assign root_out = root_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

`default_nettype wire

@@ rtl/core/rmq_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// signed numerator, unsigned divisor, magnitude quotient plus sign
`timescale 1ns / 1ps
`default_nettype none

module rmq_div #(
    parameter int NUM_W = 17,
    parameter int DSW = 17,
    parameter int FRAC = 14,
    parameter int SIDE_W = 1,
    parameter int DVW = NUM_W + FRAC
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    ce,
    input  wire                    v_in,
    input  wire signed [NUM_W-1:0] num_in,
    input  wire [DSW-1:0]          den_in,
    input  wire [SIDE_W-1:0]       side_in,
    output logic                   v_out,
    output logic [DVW-1:0]         quo_out,
    output logic                   neg_out,
    output logic [SIDE_W-1:0]      side_out
);

    logic              v_reg    [0:DVW-1];
    logic [DSW-1:0]    rem_reg  [0:DVW-1];
    logic [DVW-1:0]    quo_reg  [0:DVW-1];
    logic [DVW-1:0]    dvd_reg  [0:DVW-1];
    logic [DSW-1:0]    den_reg  [0:DVW-1];
    logic              neg_reg  [0:DVW-1];
    logic [SIDE_W-1:0] side_reg [0:DVW-1];

    logic [NUM_W-1:0] mag0;
    assign mag0 = num_in[NUM_W-1] ? NUM_W'(-num_in) : NUM_W'(num_in);

    for (genvar k = 0; k < DVW; k++) begin : g_stage
        logic              v_i, neg_i, ge;
        logic [DSW-1:0]    rem_i, den_i, rem_next;
        logic [DSW:0]      rem_sh;
        logic [DVW-1:0]    quo_i, dvd_i;
        logic [SIDE_W-1:0] side_i;

        if (k == 0) begin : g_first
            assign v_i    = v_in;
            assign rem_i  = '0;
            assign quo_i  = '0;
            assign dvd_i  = {mag0, {FRAC{1'b0}}};
            assign den_i  = den_in;
            assign neg_i  = num_in[NUM_W-1];
            assign side_i = side_in;
        end else begin : g_next
            assign v_i    = v_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign quo_i  = quo_reg[k-1];
            assign dvd_i  = dvd_reg[k-1];
            assign den_i  = den_reg[k-1];
            assign neg_i  = neg_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_i, dvd_i[DVW-1]};
            ge     = rem_sh >= {1'b0, den_i};
            rem_next = ge ? DSW'(rem_sh - {1'b0, den_i}) : rem_sh[DSW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= v_i;
            end
            if (ce) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= {quo_i[DVW-2:0], ge};
                dvd_reg[k]  <= dvd_i << 1;
                den_reg[k]  <= den_i;
                neg_reg[k]  <= neg_i;
                side_reg[k] <= side_i;
            end
        end
    end

    assign v_out    = v_reg[DVW-1];
    assign quo_out  = quo_reg[DVW-1];
    assign neg_out  = neg_reg[DVW-1];
    assign side_out = side_reg[DVW-1];

endmodule

`default_nettype wire

@@ rtl/core/rmq_out.sv @@
// saturation, component placement and the output register
// depends on rmq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmq_out
    import rmq_pkg::*;
#(
    parameter int W = 16,
    parameter int DVW = 31,
    parameter int OW = 15
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              ce,
    input  wire              v_in,
    input  branch_t          branch_in,
    input  wire              degen_in,
    input  wire [OW-1:0]     own_in,
    input  wire [DVW-1:0]    quo0_in,
    input  wire              neg0_in,
    input  wire [DVW-1:0]    quo1_in,
    input  wire              neg1_in,
    input  wire [DVW-1:0]    quo2_in,
    input  wire              neg2_in,
    output logic             v_out,
    output logic [W-1:0]     qw_out,
    output logic [W-1:0]     qx_out,
    output logic [W-1:0]     qy_out,
    output logic [W-1:0]     qz_out,
    output logic             degen_out
);

    localparam int XW = (OW > W) ? OW : W;
    localparam logic [DVW-1:0] HI_Q = DVW'({(W-1){1'b1}});
    localparam logic [XW-1:0]  HI_O = XW'({(W-1){1'b1}});
    localparam logic [W-1:0]   MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MIN_V = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_quo(input logic [DVW-1:0] mag, input logic neg);
        logic [W-1:0] r;
        if (!neg) begin
            r = (mag > HI_Q) ? MAX_V : mag[W-1:0];
        end else begin
            // magnitude of exactly 2^(W-1) negates to the minimum code
            r = (mag > HI_Q + 1'b1) ? MIN_V : W'(-mag[W-1:0]);
        end
        return r;
    endfunction

    logic [XW-1:0] own_x;
    logic [W-1:0]  own_s, a_s, b_s, c_s;
    logic [W-1:0]  qw, qx, qy, qz;

    logic v_reg, degen_reg;
    logic [W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    always_comb begin
        own_x = XW'(own_in);
        own_s = (own_x > HI_O) ? MAX_V : own_x[W-1:0];
        a_s = sat_quo(quo0_in, neg0_in);
        b_s = sat_quo(quo1_in, neg1_in);
        c_s = sat_quo(quo2_in, neg2_in);
        case (branch_in)
            BR_W: begin
                qw = own_s; qx = a_s;   qy = b_s;   qz = c_s;
            end
            BR_X: begin
                qw = a_s;   qx = own_s; qy = b_s;   qz = c_s;
            end
            BR_Y: begin
                qw = a_s;   qx = b_s;   qy = own_s; qz = c_s;
            end
            default: begin
                qw = a_s;   qx = b_s;   qy = c_s;   qz = own_s;
            end
        endcase
        if (degen_in) begin
            qw = '0; qx = '0; qy = '0; qz = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (ce) begin
            v_reg <= v_in;
        end
        if (ce) begin
            qw_reg    <= qw;
            qx_reg    <= qx;
            qy_reg    <= qy;
            qz_reg    <= qz;
            degen_reg <= degen_in;
        end
    end

    assign v_out     = v_reg;
    assign qw_out    = qw_reg;
    assign qx_out    = qx_reg;
    assign qy_out    = qy_reg;
    assign qz_out    = qz_reg;
    assign degen_out = degen_reg;

endmodule

`default_nettype wire

@@ rtl/core/rmq_checker.sv @@
// port-level checks for the rotation matrix to quaternion block
// uses rotation_matrix_to_quaternion_top_macros.svh; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none
`include "rotation_matrix_to_quaternion_top_macros.svh"

module rmq_checker #(
    parameter int DATA_WIDTH = 16
) (
    input wire                                 aclk,
    input wire                                 aresetn,
    input wire                                 s_tvalid,
    input wire                                 s_tready,
    input wire                                 m_tvalid,
    input wire                                 m_tready,
    input wire [((4*DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
    input wire [0:0]                           m_tuser
);

    `RMQ_ASSERT(a_ready_follows_out, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "input ready does not track output slot")
    `RMQ_ASSERT(a_degen_zero, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0), "degenerate transaction with nonzero quaternion")
    `RMQ_ASSERT(a_hold_stall, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")
    `RMQ_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
